// ----- rtl/core/egb_pkg.sv -----
package egb_pkg;

   // Field widths of the channels
   localparam int ACTION_W   = 2;
   localparam int XY_W       = 24;
   localparam int Z_W        = 20;
   localparam int COLOR_W    = 8;
   localparam int CELL_IDX_W = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_O_W  = 16;
   localparam int VAR_W      = 39;
   localparam int SCALE_W    = 24;
   localparam int USED_W     = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int FRAC_W     = 16;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] RSP_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_OUTSIDE = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_CLEARED = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_READ    = 3'd4;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_X_ORIGIN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_ORIGIN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CELL_SCALE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROWS_USED  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COLS_USED  = 3'd4;

   // Serial arithmetic operations of a cell read, in issue order
   typedef enum logic [2:0] {
      OP_NSQ   = 3'd0,  // count * square sum
      OP_S1SQ  = 3'd1,  // |height sum| squared
      OP_NN    = 3'd2,  // count squared
      OP_VAR   = 3'd3,  // variance divide
      OP_MEAN  = 3'd4,  // mean height divide
      OP_RED   = 3'd5,
      OP_GREEN = 3'd6,
      OP_BLUE  = 3'd7
   } op_type;

   typedef struct packed {
      logic [ACTION_W-1:0]         action;
      logic signed [XY_W-1:0]      point_x;
      logic signed [XY_W-1:0]      point_y;
      logic signed [Z_W-1:0]       point_z;
      logic [COLOR_W-1:0]          point_red;
      logic [COLOR_W-1:0]          point_green;
      logic [COLOR_W-1:0]          point_blue;
      logic [CELL_IDX_W-1:0]       cell_row;
      logic [CELL_IDX_W-1:0]       cell_col;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  cell_empty;
      logic [COUNT_O_W-1:0]  cell_points;
      logic signed [Z_W-1:0] height_min;
      logic signed [Z_W-1:0] height_max;
      logic signed [Z_W-1:0] height_mean;
      logic [VAR_W-1:0]      height_variance;
      logic [COLOR_W-1:0]    mean_red;
      logic [COLOR_W-1:0]    mean_green;
      logic [COLOR_W-1:0]    mean_blue;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic                load;
      logic                clr_step;
      logic                index_mul;
      logic                index_calc;
      logic                mem_rd;
      logic                upd_we;
      logic                cell_we;
      logic                set_empty;
      logic                status_we;
      logic [STATUS_W-1:0] status;
      op_type              op;
      logic                op_load;
      logic                op_step;
      logic                op_store;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic outside;
      logic full;
      logic empty;
   } dp_sts_type;

endpackage

// ----- rtl/core/egb_if.sv -----
interface egb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [egb_pkg::ACTION_W-1:0]          action;
   logic signed [egb_pkg::XY_W-1:0]       point_x;
   logic signed [egb_pkg::XY_W-1:0]       point_y;
   logic signed [egb_pkg::Z_W-1:0]        point_z;
   logic [egb_pkg::COLOR_W-1:0]           point_red;
   logic [egb_pkg::COLOR_W-1:0]           point_green;
   logic [egb_pkg::COLOR_W-1:0]           point_blue;
   logic [egb_pkg::CELL_IDX_W-1:0]        cell_row;
   logic [egb_pkg::CELL_IDX_W-1:0]        cell_col;

   modport source (output valid, action, point_x, point_y, point_z, point_red,
                   point_green, point_blue, cell_row, cell_col, input ready);
   modport sink (input valid, action, point_x, point_y, point_z, point_red,
                 point_green, point_blue, cell_row, cell_col, output ready);
endinterface

interface egb_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [egb_pkg::STATUS_W-1:0]          status;
   logic                                  cell_empty;
   logic [egb_pkg::COUNT_O_W-1:0]         cell_points;
   logic signed [egb_pkg::Z_W-1:0]        height_min;
   logic signed [egb_pkg::Z_W-1:0]        height_max;
   logic signed [egb_pkg::Z_W-1:0]        height_mean;
   logic [egb_pkg::VAR_W-1:0]             height_variance;
   logic [egb_pkg::COLOR_W-1:0]           mean_red;
   logic [egb_pkg::COLOR_W-1:0]           mean_green;
   logic [egb_pkg::COLOR_W-1:0]           mean_blue;

   modport source (output valid, status, cell_empty, cell_points, height_min,
                   height_max, height_mean, height_variance, mean_red,
                   mean_green, mean_blue, input ready);
   modport sink (input valid, status, cell_empty, cell_points, height_min,
                 height_max, height_mean, height_variance, mean_red,
                 mean_green, mean_blue, output ready);
endinterface

interface egb_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [egb_pkg::CSR_ADDR_W-1:0]        addr;
   logic [egb_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/egb_dp.sv -----
module egb_dp #(
   parameter int GRID_ROWS  = 256,
   parameter int GRID_COLS  = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  egb_pkg::req_payload_type       req_pl,
   input  logic                           csr_we,
   input  logic [egb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [egb_pkg::CSR_DATA_W-1:0] csr_data,
   input  egb_pkg::dp_cmd_type            cmd,
   output egb_pkg::dp_sts_type            sts,
   output egb_pkg::rsp_payload_type       rsp_pl
);

   localparam int NCELLS = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(NCELLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ZW     = egb_pkg::Z_W;
   localparam int XW     = egb_pkg::XY_W;
   localparam int S1_W   = COUNT_BITS + ZW;
   localparam int S2_W   = COUNT_BITS + 2 * ZW - 2;
   localparam int CS_W   = COUNT_BITS + egb_pkg::COLOR_W;
   localparam int ACC_W  = 2 * COUNT_BITS + 2 * ZW;
   localparam int DEN_W  = 2 * COUNT_BITS;
   localparam int PROD_W = XW + egb_pkg::SCALE_W;
   localparam int ZSQ_W  = 2 * ZW - 1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] cnt;
      logic signed [ZW-1:0]  hmin;
      logic signed [ZW-1:0]  hmax;
      logic signed [S1_W-1:0] s1;
      logic [S2_W-1:0]       s2;
      logic [CS_W-1:0]       red;
      logic [CS_W-1:0]       green;
      logic [CS_W-1:0]       blue;
   } cell_type;

   cell_type mem [NCELLS];

   // configuration
   logic signed [XW-1:0]                  x_org_ff, y_org_ff;
   logic [egb_pkg::SCALE_W-1:0]           scale_ff;
   logic [egb_pkg::USED_W-1:0]            rows_ff, cols_ff;

   // item registers
   logic                                  is_read_ff;
   logic signed [XW:0]                    dx_ff, dy_ff;
   logic signed [ZW-1:0]                  z_ff;
   logic [egb_pkg::COLOR_W-1:0]           red_ff, green_ff, blue_ff;
   logic [egb_pkg::CELL_IDX_W-1:0]        row_ff, col_ff;
   logic [PROD_W-1:0]                     xprod_ff, yprod_ff;
   logic                                  neg_ff;
   logic [ZSQ_W-1:0]                      zsq_ff;
   logic                                  outside_ff;
   logic [ADDR_W-1:0]                     addr_ff, clr_ptr_ff;
   cell_type                              rd_ff;

   // serial arithmetic
   logic [ACC_W-1:0]                      acc_ff, mcand_ff, p1_ff, p2_ff, quo_ff;
   logic [S1_W-1:0]                       mplier_ff;
   logic [DEN_W-1:0]                      nn_ff, rem_ff, den_ff;

   // result
   egb_pkg::rsp_payload_type              res_ff;

   logic signed [2*ZW-1:0]                zsq_full;
   logic [31:0]                           xi, yi, lim_r, lim_c;
   cell_type                              upd;
   logic                                  first;
   logic [S1_W-1:0]                       abs_s1;
   logic                                  is_mul;
   logic [DEN_W:0]                        trial, diff;
   logic                                  ge;
   logic [31:0]                           cnt32;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_org_ff <= '0;
         y_org_ff <= '0;
         scale_ff <= egb_pkg::SCALE_W'(2560);
         rows_ff  <= egb_pkg::USED_W'(256);
         cols_ff  <= egb_pkg::USED_W'(256);
      end else if (csr_we) begin
         case (csr_addr)
            egb_pkg::REG_X_ORIGIN:   x_org_ff <= csr_data[XW-1:0];
            egb_pkg::REG_Y_ORIGIN:   y_org_ff <= csr_data[XW-1:0];
            egb_pkg::REG_CELL_SCALE: scale_ff <= csr_data[egb_pkg::SCALE_W-1:0];
            egb_pkg::REG_ROWS_USED:  rows_ff  <= csr_data[egb_pkg::USED_W-1:0];
            egb_pkg::REG_COLS_USED:  cols_ff  <= csr_data[egb_pkg::USED_W-1:0];
            default: ;
         endcase
      end
   end

   // index arithmetic
   assign zsq_full = z_ff * z_ff;
   assign xi = is_read_ff ? 32'(row_ff) : 32'(xprod_ff[PROD_W-1:egb_pkg::FRAC_W]);
   assign yi = is_read_ff ? 32'(col_ff) : 32'(yprod_ff[PROD_W-1:egb_pkg::FRAC_W]);
   assign lim_r = (32'(rows_ff) < 32'(GRID_ROWS)) ? 32'(rows_ff) : 32'(GRID_ROWS);
   assign lim_c = (32'(cols_ff) < 32'(GRID_COLS)) ? 32'(cols_ff) : 32'(GRID_COLS);

   // latch the item, form offsets, products and the cell address
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= (req_pl.action == egb_pkg::ACT_READ);
         dx_ff      <= {req_pl.point_x[XW-1], req_pl.point_x} - {x_org_ff[XW-1], x_org_ff};
         dy_ff      <= {req_pl.point_y[XW-1], req_pl.point_y} - {y_org_ff[XW-1], y_org_ff};
         z_ff       <= req_pl.point_z;
         red_ff     <= req_pl.point_red;
         green_ff   <= req_pl.point_green;
         blue_ff    <= req_pl.point_blue;
         row_ff     <= req_pl.cell_row;
         col_ff     <= req_pl.cell_col;
      end
      if (cmd.index_mul) begin
         xprod_ff <= dx_ff[XW-1:0] * scale_ff;
         yprod_ff <= dy_ff[XW-1:0] * scale_ff;
         neg_ff   <= dx_ff[XW] | dy_ff[XW];
         zsq_ff   <= zsq_full[ZSQ_W-1:0];
      end
      if (cmd.index_calc) begin
         outside_ff <= (!is_read_ff && neg_ff) || (xi >= lim_r) || (yi >= lim_c);
         addr_ff    <= ADDR_W'(32'(xi[ROW_W-1:0]) * 32'(GRID_COLS) + 32'(yi[COL_W-1:0]));
      end
   end

   // clear pointer walks the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ptr_ff <= (clr_ptr_ff == ADDR_W'(NCELLS - 1)) ? '0 : clr_ptr_ff + ADDR_W'(1);
      end
   end

   // updated cell word
   assign first = (rd_ff.cnt == '0);
   always_comb begin
      upd       = rd_ff;
      upd.cnt   = rd_ff.cnt + COUNT_BITS'(1);
      upd.hmin  = (first || z_ff < rd_ff.hmin) ? z_ff : rd_ff.hmin;
      upd.hmax  = (first || z_ff > rd_ff.hmax) ? z_ff : rd_ff.hmax;
      upd.s1    = rd_ff.s1 + {{(S1_W - ZW){z_ff[ZW-1]}}, z_ff};
      upd.s2    = rd_ff.s2 + S2_W'(zsq_ff);
      upd.red   = rd_ff.red + CS_W'(red_ff);
      upd.green = rd_ff.green + CS_W'(green_ff);
      upd.blue  = rd_ff.blue + CS_W'(blue_ff);
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ptr_ff] <= '0;
      end else if (cmd.upd_we) begin
         mem[addr_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_ff <= mem[addr_ff];
      end
   end

   // serial multiply and restoring divide
   assign abs_s1 = rd_ff.s1[S1_W-1] ? (~rd_ff.s1 + S1_W'(1)) : rd_ff.s1;
   assign is_mul = (cmd.op == egb_pkg::OP_NSQ) || (cmd.op == egb_pkg::OP_S1SQ) ||
                   (cmd.op == egb_pkg::OP_NN);
   assign trial  = {rem_ff, quo_ff[ACC_W-1]};
   assign ge     = (trial >= {1'b0, den_ff});
   assign diff   = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         acc_ff <= '0;
         rem_ff <= '0;
         case (cmd.op)
            egb_pkg::OP_NSQ: begin
               mplier_ff <= S1_W'(rd_ff.cnt);
               mcand_ff  <= ACC_W'(rd_ff.s2);
            end
            egb_pkg::OP_S1SQ: begin
               mplier_ff <= abs_s1;
               mcand_ff  <= ACC_W'(abs_s1);
            end
            egb_pkg::OP_NN: begin
               mplier_ff <= S1_W'(rd_ff.cnt);
               mcand_ff  <= ACC_W'(rd_ff.cnt);
            end
            egb_pkg::OP_VAR: begin
               quo_ff <= p1_ff - p2_ff;
               den_ff <= nn_ff;
            end
            egb_pkg::OP_MEAN: begin
               quo_ff <= ACC_W'(abs_s1);
               den_ff <= DEN_W'(rd_ff.cnt);
            end
            egb_pkg::OP_RED: begin
               quo_ff <= ACC_W'(rd_ff.red);
               den_ff <= DEN_W'(rd_ff.cnt);
            end
            egb_pkg::OP_GREEN: begin
               quo_ff <= ACC_W'(rd_ff.green);
               den_ff <= DEN_W'(rd_ff.cnt);
            end
            default: begin
               quo_ff <= ACC_W'(rd_ff.blue);
               den_ff <= DEN_W'(rd_ff.cnt);
            end
         endcase
      end else if (cmd.op_step) begin
         if (is_mul) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[S1_W-1:1]};
         end else begin
            rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], ge};
         end
      end
   end

   // result register
   assign cnt32 = 32'(rd_ff.cnt);
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= '0;
      end else begin
         if (cmd.status_we) begin
            res_ff.status <= cmd.status;
         end
         if (cmd.set_empty) begin
            res_ff.cell_empty <= 1'b1;
         end
         if (cmd.cell_we) begin
            res_ff.cell_points <= (cnt32 > 32'(16'hFFFF)) ? 16'hFFFF :
                                  cnt32[egb_pkg::COUNT_O_W-1:0];
            res_ff.height_min  <= rd_ff.hmin;
            res_ff.height_max  <= rd_ff.hmax;
         end
         if (cmd.op_store) begin
            case (cmd.op)
               egb_pkg::OP_NSQ:   p1_ff <= acc_ff;
               egb_pkg::OP_S1SQ:  p2_ff <= acc_ff;
               egb_pkg::OP_NN:    nn_ff <= acc_ff[DEN_W-1:0];
               egb_pkg::OP_VAR:   res_ff.height_variance <= quo_ff[egb_pkg::VAR_W-1:0];
               egb_pkg::OP_MEAN:
                  res_ff.height_mean <= rd_ff.s1[S1_W-1] ? (~quo_ff[ZW-1:0] + ZW'(1)) :
                                        quo_ff[ZW-1:0];
               egb_pkg::OP_RED:   res_ff.mean_red   <= quo_ff[egb_pkg::COLOR_W-1:0];
               egb_pkg::OP_GREEN: res_ff.mean_green <= quo_ff[egb_pkg::COLOR_W-1:0];
               default:           res_ff.mean_blue  <= quo_ff[egb_pkg::COLOR_W-1:0];
            endcase
         end
      end
   end

   assign sts.clr_last = (clr_ptr_ff == ADDR_W'(NCELLS - 1));
   assign sts.outside  = outside_ff;
   assign sts.full     = &rd_ff.cnt;
   assign sts.empty    = first;
   assign rsp_pl       = res_ff;

   // a full cell is never written back
   a_no_full_write: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_we |-> !(&rd_ff.cnt))
      else $error("update of a full cell");

   // a clear step and an update never share the write port
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && cmd.upd_we))
      else $error("two writes in one cycle");

   // an add's address is only formed after the products are in
   a_idx_order: assert property (@(posedge clock) disable iff (reset)
      cmd.index_calc |-> ($past(cmd.index_mul) || is_read_ff))
      else $error("index formed without products");

endmodule

// ----- rtl/core/egb_ctrl.sv -----
module egb_ctrl #(
   parameter int MUL_STEPS = 36,
   parameter int DIV_STEPS = 72
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [egb_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  egb_pkg::dp_sts_type          sts,
   output egb_pkg::dp_cmd_type          cmd
);

   localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);

   typedef enum logic [11:0] {
      S_INIT   = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_CLEAR  = 12'b000000000100,
      S_MUL    = 12'b000000001000,
      S_INDEX  = 12'b000000010000,
      S_FETCH  = 12'b000000100000,
      S_UPDATE = 12'b000001000000,
      S_CHECK  = 12'b000010000000,
      S_LOAD   = 12'b000100000000,
      S_STEP   = 12'b001000000000,
      S_STORE  = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type              state_ff, state_in;
   egb_pkg::op_type        op_ff, op_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic                   read_ff, read_in;
   logic                   accept;
   logic                   op_mul;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign accept    = req_valid && req_ready;
   assign op_mul    = (op_ff == egb_pkg::OP_NSQ) || (op_ff == egb_pkg::OP_S1SQ) ||
                      (op_ff == egb_pkg::OP_NN);

   // sequence the item
   always_comb begin
      cmd      = '0;
      cmd.op   = op_ff;
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      read_in  = read_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               read_in  = (req_action == egb_pkg::ACT_READ);
               case (req_action)
                  egb_pkg::ACT_CLEAR: state_in = S_CLEAR;
                  egb_pkg::ACT_ADD:   state_in = S_MUL;
                  egb_pkg::ACT_READ:  state_in = S_INDEX;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.status_we = 1'b1;
               cmd.status    = egb_pkg::RSP_CLEARED;
               state_in      = S_RESP;
            end
         end
         S_MUL: begin
            cmd.index_mul = 1'b1;
            state_in      = S_INDEX;
         end
         S_INDEX: begin
            cmd.index_calc = 1'b1;
            state_in       = S_FETCH;
         end
         S_FETCH: begin
            if (sts.outside) begin
               cmd.status_we = 1'b1;
               cmd.status    = egb_pkg::RSP_OUTSIDE;
               state_in      = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = read_ff ? S_CHECK : S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.status_we = 1'b1;
            if (sts.full) begin
               cmd.status = egb_pkg::RSP_FULL;
            end else begin
               cmd.upd_we = 1'b1;
               cmd.status = egb_pkg::RSP_ADDED;
            end
            state_in = S_RESP;
         end
         S_CHECK: begin
            cmd.status_we = 1'b1;
            cmd.status    = egb_pkg::RSP_READ;
            if (sts.empty) begin
               cmd.set_empty = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.cell_we = 1'b1;
               op_in       = egb_pkg::OP_NSQ;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.op_load = 1'b1;
            cnt_in      = op_mul ? STEP_W'(MUL_STEPS) : STEP_W'(DIV_STEPS);
            state_in    = S_STEP;
         end
         S_STEP: begin
            cmd.op_step = 1'b1;
            cnt_in      = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op_store = 1'b1;
            if (op_ff == egb_pkg::OP_BLUE) begin
               state_in = S_RESP;
            end else begin
               op_in    = egb_pkg::op_type'(op_ff + 3'd1);
               state_in = S_LOAD;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         op_ff    <= egb_pkg::OP_NSQ;
         cnt_ff   <= '0;
         read_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         read_ff  <= read_in;
      end
   end

   // never take a beat while a result is offered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   // the step counter never runs out inside a step run
   a_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (cnt_ff != '0))
      else $error("step counter underflow");

   // the last divide hands over to the result
   a_last_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE && op_ff == egb_pkg::OP_BLUE) |=> (state_ff == S_RESP))
      else $error("read did not finish");

endmodule

// ----- rtl/core/elevation_grid_binning_unit.sv -----
// Elevation grid binning unit.
// req_chan takes one beat per item: clear grid, add point or read cell.
// rsp_chan returns exactly one beat per clear, add or read item; action 3
// is dropped without a result. csr_chan writes the five grid registers and
// is always ready; write it only while the unit is idle.
// One item is worked at a time; req_chan is ready only while idle, so the
// next item can be taken in the cycle after the result beat.
// Steps of each item, from the accepting edge to the result:
//   add     offset, scale multiply, index, fetch, update
//   clear   every cell of the store, one cell written per cycle
//   read    outside: index, fetch; empty: index, fetch, check; otherwise
//           index, fetch, check, then three multiplies and five divides,
//           done by the bit-serial multiply and restoring divide unit.
// After reset the cell store is swept once, with req_chan held not ready;
// registers return to their defaults.
// A result is held in its register until rsp_chan.ready takes it; the
// unit accepts no new item meanwhile.
module elevation_grid_binning_unit #(
   parameter int GRID_ROWS  = 256,
   parameter int GRID_COLS  = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   egb_req_if.sink   req_chan,
   egb_rsp_if.source rsp_chan,
   egb_csr_if.sink   csr_chan
);

   localparam int MUL_STEPS = COUNT_BITS + egb_pkg::Z_W;
   localparam int DIV_STEPS = 2 * COUNT_BITS + 2 * egb_pkg::Z_W;

   egb_pkg::req_payload_type req_pl;
   egb_pkg::rsp_payload_type rsp_pl;
   egb_pkg::dp_cmd_type      cmd;
   egb_pkg::dp_sts_type      sts;
   logic                     csr_we;

   // gather the request beat
   assign req_pl.action      = req_chan.action;
   assign req_pl.point_x     = req_chan.point_x;
   assign req_pl.point_y     = req_chan.point_y;
   assign req_pl.point_z     = req_chan.point_z;
   assign req_pl.point_red   = req_chan.point_red;
   assign req_pl.point_green = req_chan.point_green;
   assign req_pl.point_blue  = req_chan.point_blue;
   assign req_pl.cell_row    = req_chan.cell_row;
   assign req_pl.cell_col    = req_chan.cell_col;

   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid;

   egb_ctrl #(
      .MUL_STEPS (MUL_STEPS),
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   egb_dp #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_pl   (req_pl),
      .csr_we   (csr_we),
      .csr_addr (csr_chan.addr),
      .csr_data (csr_chan.data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_pl   (rsp_pl)
   );

   // scatter the result beat
   assign rsp_chan.status          = rsp_pl.status;
   assign rsp_chan.cell_empty      = rsp_pl.cell_empty;
   assign rsp_chan.cell_points     = rsp_pl.cell_points;
   assign rsp_chan.height_min      = rsp_pl.height_min;
   assign rsp_chan.height_max      = rsp_pl.height_max;
   assign rsp_chan.height_mean     = rsp_pl.height_mean;
   assign rsp_chan.height_variance = rsp_pl.height_variance;
   assign rsp_chan.mean_red        = rsp_pl.mean_red;
   assign rsp_chan.mean_green      = rsp_pl.mean_green;
   assign rsp_chan.mean_blue       = rsp_pl.mean_blue;

endmodule

// ----- tb/testbench.sv -----
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 600;
   localparam int STALL_LIMIT   = 200000;
   localparam int FULL_COUNT    = 65535;

   typedef enum logic [1:0] {STEP_ITEM, STEP_CSR, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type            kind;
      egb_pkg::req_payload_type item;
      logic [2:0]               addr;
      logic [23:0]              data;
      bit                       calm;
   } plan_step_type;

   logic clock;
   logic reset;

   egb_req_if req_bus();
   egb_rsp_if rsp_bus();
   egb_csr_if csr_bus();

   elevation_grid_binning_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   plan_step_type            plan[$];
   egb_pkg::rsp_payload_type expect_q[$];
   int                       errors = 0;
   bit                       calm_now = 0;

   // Grid model: register copy and per-cell statistics
   logic signed [23:0] org_x, org_y;
   logic [23:0]        scale;
   logic [8:0]         rows, cols;
   int unsigned        cnt[int];
   int                 zmin[int], zmax[int];
   longint             hsum[int];
   logic [63:0]        sqsum[int];
   int unsigned        rsum[int], gsum[int], bsum[int];

   // Settings seen while planning stimulus
   logic signed [23:0] aim_x, aim_y;
   logic [23:0]        aim_scale;
   logic [8:0]         aim_rows, aim_cols;

   // Work out the result of one item and update the grid model
   function automatic bit grid_step(input egb_pkg::req_payload_type it,
                                    output egb_pkg::rsp_payload_type res);
      longint      dx, dy, xi, yi, z, s1, a;
      int          lr, lc, c;
      int unsigned n;
      logic [127:0] num, p2, den, quo;
      res = '0;
      lr = (rows > 256) ? 256 : int'(rows);
      lc = (cols > 256) ? 256 : int'(cols);
      case (it.action)
         egb_pkg::ACT_CLEAR: begin
            cnt.delete();
            res.status = egb_pkg::RSP_CLEARED;
            return 1;
         end
         egb_pkg::ACT_ADD: begin
            dx = longint'(it.point_x) - longint'(org_x);
            dy = longint'(it.point_y) - longint'(org_y);
            z  = longint'(it.point_z);
            if (dx < 0 || dy < 0) begin
               res.status = egb_pkg::RSP_OUTSIDE;
               return 1;
            end
            xi = (dx * longint'(scale)) >> 16;
            yi = (dy * longint'(scale)) >> 16;
            if (xi >= lr || yi >= lc) begin
               res.status = egb_pkg::RSP_OUTSIDE;
               return 1;
            end
            c = int'(xi * 256 + yi);
            n = cnt.exists(c) ? cnt[c] : 0;
            if (n >= FULL_COUNT) begin
               res.status = egb_pkg::RSP_FULL;
               return 1;
            end
            if (n == 0) begin
               zmin[c] = int'(z);
               zmax[c] = int'(z);
               hsum[c] = 0;
               sqsum[c] = '0;
               rsum[c] = 0;
               gsum[c] = 0;
               bsum[c] = 0;
            end
            if (z < zmin[c]) zmin[c] = int'(z);
            if (z > zmax[c]) zmax[c] = int'(z);
            cnt[c]   = n + 1;
            hsum[c]  += z;
            sqsum[c] += 64'(z * z);
            rsum[c]  += it.point_red;
            gsum[c]  += it.point_green;
            bsum[c]  += it.point_blue;
            res.status = egb_pkg::RSP_ADDED;
            return 1;
         end
         egb_pkg::ACT_READ: begin
            if (it.cell_row >= lr || it.cell_col >= lc) begin
               res.status = egb_pkg::RSP_OUTSIDE;
               return 1;
            end
            c = int'(it.cell_row) * 256 + int'(it.cell_col);
            n = cnt.exists(c) ? cnt[c] : 0;
            res.status = egb_pkg::RSP_READ;
            if (n == 0) begin
               res.cell_empty = 1'b1;
               return 1;
            end
            s1 = hsum[c];
            a  = (s1 < 0) ? -s1 : s1;
            num = 128'(n) * 128'(sqsum[c]);
            p2  = 128'(a) * 128'(a);
            den = 128'(n) * 128'(n);
            quo = (num - p2) / den;
            res.cell_points     = (n > 65535) ? 16'hFFFF : n[15:0];
            res.height_min      = zmin[c][19:0];
            res.height_max      = zmax[c][19:0];
            res.height_mean     = 20'(s1 / longint'(n));
            res.height_variance = quo[38:0];
            res.mean_red        = 8'(rsum[c] / n);
            res.mean_green      = 8'(gsum[c] / n);
            res.mean_blue       = 8'(bsum[c] / n);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic egb_pkg::req_payload_type mk(logic [1:0] act, int x, int y, int z,
                                                   int r, int g, int b, int row, int col);
      egb_pkg::req_payload_type it;
      it.action      = act;
      it.point_x     = x[23:0];
      it.point_y     = y[23:0];
      it.point_z     = z[19:0];
      it.point_red   = r[7:0];
      it.point_green = g[7:0];
      it.point_blue  = b[7:0];
      it.cell_row    = row[7:0];
      it.cell_col    = col[7:0];
      return it;
   endfunction

   task automatic push_item(egb_pkg::req_payload_type it, bit calm);
      plan_step_type s;
      s.kind = STEP_ITEM;
      s.item = it;
      s.addr = '0;
      s.data = '0;
      s.calm = calm;
      plan.insert(plan.size(), s);
   endtask

   task automatic push_drain();
      plan_step_type s;
      s.kind = STEP_DRAIN;
      s.item = '0;
      s.addr = '0;
      s.data = '0;
      s.calm = 0;
      plan.insert(plan.size(), s);
   endtask

   task automatic push_csr(logic [2:0] addr, logic [23:0] data);
      plan_step_type s;
      s.kind = STEP_CSR;
      s.item = '0;
      s.addr = addr;
      s.data = data;
      s.calm = 0;
      plan.insert(plan.size(), s);
   endtask

   // Wait for idle, then write all five registers
   task automatic set_grid(int xo, int yo, int sc, int rw, int cl);
      push_drain();
      push_csr(egb_pkg::REG_X_ORIGIN, xo[23:0]);
      push_csr(egb_pkg::REG_Y_ORIGIN, yo[23:0]);
      push_csr(egb_pkg::REG_CELL_SCALE, sc[23:0]);
      push_csr(egb_pkg::REG_ROWS_USED, 24'(rw[8:0]));
      push_csr(egb_pkg::REG_COLS_USED, 24'(cl[8:0]));
      aim_x = xo[23:0];
      aim_y = yo[23:0];
      aim_scale = sc[23:0];
      aim_rows = rw[8:0];
      aim_cols = cl[8:0];
   endtask

   // Random offset that mostly lands inside the used area along one axis
   function automatic longint aim_offset(int lim);
      longint span;
      span = (aim_scale == 0) ? 4096 : (longint'(lim) * 65536) / aim_scale + 2;
      if (span > 16777216) span = 16777216;
      return longint'($urandom_range(0, int'(span + span / 8))) - span / 16;
   endfunction

   task automatic rand_item(bit calm);
      int  r, lr, lc, z, row, col;
      egb_pkg::req_payload_type it;
      r  = $urandom_range(0, 99);
      lr = (aim_rows > 256) ? 256 : int'(aim_rows);
      lc = (aim_cols > 256) ? 256 : int'(aim_cols);
      z  = ($urandom_range(0, 1) == 1) ? int'($urandom()) : $urandom_range(0, 4000) - 2000;
      if (r < 3) begin
         it = mk(egb_pkg::ACT_UNKNOWN, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom());
      end else if (r < 50) begin
         it = mk(egb_pkg::ACT_ADD, int'(longint'(aim_x) + aim_offset(lr)),
                 int'(longint'(aim_y) + aim_offset(lc)), z, $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom());
      end else if (r < 60) begin
         it = mk(egb_pkg::ACT_ADD, $urandom(), $urandom(), z, $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom());
      end else begin
         if ($urandom_range(0, 4) != 0) begin
            row = $urandom_range(0, (lr > 255) ? 255 : lr);
            col = $urandom_range(0, (lc > 255) ? 255 : lc);
         end else begin
            row = $urandom();
            col = $urandom();
         end
         it = mk(egb_pkg::ACT_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), row, col);
      end
      push_item(it, calm);
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Reset, stimulus plan and end of run
   initial begin
      reset = 1'b1;

      // Directed part under the reset settings
      aim_x = '0; aim_y = '0; aim_scale = 24'd2560; aim_rows = 9'd256; aim_cols = 9'd256;
      push_item(mk(egb_pkg::ACT_ADD, 0, 0, -524288, 0, 0, 0, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, 0, 0, 524287, 255, 255, 255, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, 10, 20, 0, 128, 1, 254, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, -1, 0, 5, 1, 2, 3, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, 0, -8388608, 5, 1, 2, 3, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, 8388607, 0, 5, 1, 2, 3, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_ADD, 6540, 6540, -7, 9, 8, 7, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 255, 255), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 17, 200), 0);
      push_item(mk(egb_pkg::ACT_UNKNOWN, -1, -1, -1, 255, 255, 255, 255, 255), 0);
      push_item(mk(egb_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 255, 0), 0);
      repeat (60) rand_item(0);

      // Random phases across register settings, extremes among them
      set_grid(-8388608, -8388608, 1, 256, 256);
      repeat (80) rand_item(0);
      set_grid(8388607, 8388607, 16777215, 1, 1);
      push_item(mk(egb_pkg::ACT_ADD, 8388607, 8388607, 33, 4, 5, 6, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      repeat (30) rand_item(0);
      set_grid(-500, 1200, 16384, 2, 2);
      repeat (100) rand_item(1);
      repeat (100) rand_item(0);
      set_grid(0, 0, 0, 0, 300);
      repeat (30) rand_item(0);
      set_grid(77, -3, 0, 300, 5);
      repeat (40) rand_item(0);
      set_grid(12345, -54321, 4096, 16, 16);
      repeat (150) rand_item(0);
      push_drain();
      repeat (150) rand_item(0);
      set_grid(0, 0, 65536, 5, 7);
      repeat (160) rand_item(0);

      // Single cell grid: clear, add twice, read back
      set_grid(0, 0, 1, 1, 1);
      push_item(mk(egb_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      repeat (2) push_item(mk(egb_pkg::ACT_ADD, 1, 1, 0, 0, 0, 0, 0, 0), 0);
      push_item(mk(egb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Hold until all stimulus is taken and answered
      while (plan.size() != 0 || req_bus.valid || csr_bus.valid || expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (expect_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expect_q.size());
         end
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Driver: items and register writes from the plan queue
   int       gap_left = 0;
   int       settle_cnt = 0;
   egb_pkg::req_payload_type cur_item;
   always @(posedge clock) begin
      egb_pkg::rsp_payload_type res;
      bit req_busy, csr_busy;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         org_x = '0;
         org_y = '0;
         scale = 24'd2560;
         rows  = 9'd256;
         cols  = 9'd256;
         cnt.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (grid_step(cur_item, res)) expect_q.insert(expect_q.size(), res);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.addr)
               egb_pkg::REG_X_ORIGIN:   org_x = csr_bus.data;
               egb_pkg::REG_Y_ORIGIN:   org_y = csr_bus.data;
               egb_pkg::REG_CELL_SCALE: scale = csr_bus.data;
               egb_pkg::REG_ROWS_USED:  rows  = csr_bus.data[8:0];
               egb_pkg::REG_COLS_USED:  cols  = csr_bus.data[8:0];
               default: ;
            endcase
         end
         req_busy = req_bus.valid && !req_bus.ready;
         csr_busy = csr_bus.valid && !csr_bus.ready;
         if (!req_busy && !csr_busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
               csr_bus.valid <= 1'b0;
            end else if (plan.size() == 0) begin
               req_bus.valid <= 1'b0;
               csr_bus.valid <= 1'b0;
            end else begin
               case (plan[0].kind)
                  STEP_ITEM: begin
                     cur_item = plan[0].item;
                     calm_now <= plan[0].calm;
                     req_bus.action      <= cur_item.action;
                     req_bus.point_x     <= cur_item.point_x;
                     req_bus.point_y     <= cur_item.point_y;
                     req_bus.point_z     <= cur_item.point_z;
                     req_bus.point_red   <= cur_item.point_red;
                     req_bus.point_green <= cur_item.point_green;
                     req_bus.point_blue  <= cur_item.point_blue;
                     req_bus.cell_row    <= cur_item.cell_row;
                     req_bus.cell_col    <= cur_item.cell_col;
                     req_bus.valid <= 1'b1;
                     csr_bus.valid <= 1'b0;
                     gap_left <= plan[0].calm ? 0 : pick_gap();
                     void'(plan.pop_front());
                  end
                  STEP_CSR: begin
                     csr_bus.addr  <= plan[0].addr;
                     csr_bus.data  <= plan[0].data;
                     csr_bus.valid <= 1'b1;
                     req_bus.valid <= 1'b0;
                     void'(plan.pop_front());
                  end
                  default: begin
                     // Hold until every result is back and the unit has settled
                     req_bus.valid <= 1'b0;
                     csr_bus.valid <= 1'b0;
                     if (expect_q.size() != 0) begin
                        settle_cnt <= 0;
                     end else if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt <= 0;
                        void'(plan.pop_front());
                     end else begin
                        settle_cnt <= settle_cnt + 1;
                     end
                  end
               endcase
            end
         end
      end
   end

   // Monitor: random back-pressure and result check
   int stall_left = 0;
   always @(posedge clock) begin
      egb_pkg::rsp_payload_type exp_r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expect_q.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, status %0d",
                        $realtime, rsp_bus.status);
            end else begin
               exp_r = expect_q.pop_front();
               check_field("status", 64'(exp_r.status), 64'(rsp_bus.status));
               check_field("cell_empty", 64'(exp_r.cell_empty), 64'(rsp_bus.cell_empty));
               check_field("cell_points", 64'(exp_r.cell_points), 64'(rsp_bus.cell_points));
               check_field("height_min", 64'(exp_r.height_min), 64'(rsp_bus.height_min));
               check_field("height_max", 64'(exp_r.height_max), 64'(rsp_bus.height_max));
               check_field("height_mean", 64'(exp_r.height_mean), 64'(rsp_bus.height_mean));
               check_field("height_variance", 64'(exp_r.height_variance),
                           64'(rsp_bus.height_variance));
               check_field("mean_red", 64'(exp_r.mean_red), 64'(rsp_bus.mean_red));
               check_field("mean_green", 64'(exp_r.mean_green), 64'(rsp_bus.mean_green));
               check_field("mean_blue", 64'(exp_r.mean_blue), 64'(rsp_bus.mean_blue));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready && !calm_now) stall_left <= pick_gap();
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
